[rtl/core/icadf_pkg.sv]
// Shared types and constants for the IPv4 CIDR allow/deny filter.
// No dependencies; imported by the controller, datapath and top level.
package icadf_pkg;

  localparam int ADDR_W             = 32;
  localparam int PLEN_W             = 6;
  localparam int CMD_W              = 2;
  localparam int STATUS_W           = 2;
  localparam int RULE_DEPTH_DEFAULT = 16;

  localparam logic [PLEN_W-1:0] PLEN_MAX = PLEN_W'(ADDR_W);

  localparam logic [CMD_W-1:0] CMD_ADD_ALLOW = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD_DENY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CHECK     = 2'd2;

  localparam logic [STATUS_W-1:0] ST_ADDED      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_PREFIX = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN_ADD,
    S_SCAN_ALLOW,
    S_SCAN_DENY,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic                load;
    logic                scan_start;
    logic                scan_sel;
    logic                scan_en;
    logic                write;
    logic                res_load;
    logic                res_default;
    logic                res_allowed;
    logic [STATUS_W-1:0] res_status;
    logic                emit;
  } ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             bad_prefix;
    logic             match;
    logic             done;
    logic             full;
  } sts_t;

endpackage

[rtl/core/icadf_ctrl.sv]
// Sequencer for the CIDR filter: decode, rule scans, result hand-off.
// Depends on icadf_pkg.
module icadf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  icadf_pkg::sts_t    sts,
  output icadf_pkg::ctl_t    ctl
);
  import icadf_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.cmd == CMD_CHECK) begin
          ctl.scan_start = 1'b1;
          ctl.scan_sel   = 1'b0;
          state_next     = S_SCAN_ALLOW;
        end else if (sts.cmd == CMD_ADD_ALLOW || sts.cmd == CMD_ADD_DENY) begin
          if (sts.bad_prefix) begin
            ctl.res_load   = 1'b1;
            ctl.res_status = ST_BAD_PREFIX;
            state_next     = S_EMIT;
          end else begin
            ctl.scan_start = 1'b1;
            ctl.scan_sel   = (sts.cmd == CMD_ADD_DENY);
            state_next     = S_SCAN_ADD;
          end
        end else begin
          ctl.res_load = 1'b1;
          state_next   = S_EMIT;
        end
      end
      S_SCAN_ADD: begin
        ctl.scan_en = 1'b1;
        if (sts.match) begin
          ctl.res_load   = 1'b1;
          ctl.res_status = ST_PRESENT;
          state_next     = S_EMIT;
        end else if (sts.done) begin
          ctl.res_load = 1'b1;
          if (sts.full) begin
            ctl.res_status = ST_FULL;
          end else begin
            ctl.write      = 1'b1;
            ctl.res_status = ST_ADDED;
          end
          state_next = S_EMIT;
        end
      end
      S_SCAN_ALLOW: begin
        ctl.scan_en = 1'b1;
        if (sts.match) begin
          ctl.res_load    = 1'b1;
          ctl.res_allowed = 1'b1;
          state_next      = S_EMIT;
        end else if (sts.done) begin
          ctl.scan_start = 1'b1;
          ctl.scan_sel   = 1'b1;
          state_next     = S_SCAN_DENY;
        end
      end
      S_SCAN_DENY: begin
        ctl.scan_en = 1'b1;
        if (sts.match) begin
          ctl.res_load = 1'b1;
          state_next   = S_EMIT;
        end else if (sts.done) begin
          ctl.res_load    = 1'b1;
          ctl.res_default = 1'b1;
          state_next      = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          ctl.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    out_valid_next = ctl.emit | (out_valid & ~out_ready);
  end

endmodule

[rtl/core/icadf_dp.sv]
// Datapath for the CIDR filter: command latch, rule memories, match compare,
// result and output registers. Depends on icadf_pkg.
module icadf_dp #(
  parameter int RULE_DEPTH = icadf_pkg::RULE_DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  icadf_pkg::ctl_t                ctl,
  output icadf_pkg::sts_t                sts,
  input  logic [icadf_pkg::CMD_W-1:0]    command,
  input  logic [icadf_pkg::ADDR_W-1:0]   address,
  input  logic [icadf_pkg::PLEN_W-1:0]   prefix_len,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_wr_data,
  output logic                           allowed,
  output logic [icadf_pkg::STATUS_W-1:0] add_status
);
  import icadf_pkg::*;

  localparam int CNT_W = $clog2(RULE_DEPTH + 1);
  localparam int IDX_W = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;

  logic [2*ADDR_W-1:0] allow_mem [RULE_DEPTH];
  logic [2*ADDR_W-1:0] deny_mem  [RULE_DEPTH];

  logic [CMD_W-1:0]    cmd_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [ADDR_W-1:0]   mask_q;
  logic [ADDR_W-1:0]   net_q;
  logic                bad_q;
  logic [ADDR_W-1:0]   mask_in;

  logic [CNT_W-1:0]    allow_count;
  logic [CNT_W-1:0]    deny_count;
  logic [CNT_W-1:0]    cur_count;
  logic [CNT_W-1:0]    idx;
  logic                sel;
  logic                rd_vld;
  logic [2*ADDR_W-1:0] rd_data;
  logic [ADDR_W-1:0]   rd_net;
  logic [ADDR_W-1:0]   rd_mask;
  logic                issue;
  logic                hit;

  logic                default_allow;
  logic                res_allowed;
  logic [STATUS_W-1:0] res_status;

  assign mask_in   = {ADDR_W{1'b1}} << (PLEN_MAX - prefix_len);
  assign cur_count = sel ? deny_count : allow_count;
  assign issue     = ctl.scan_en && (idx < cur_count);
  assign rd_net    = rd_data[2*ADDR_W-1:ADDR_W];
  assign rd_mask   = rd_data[ADDR_W-1:0];

  always_comb begin
    if (cmd_q == CMD_CHECK) begin
      hit = ((addr_q & rd_mask) == rd_net);
    end else begin
      hit = (rd_net == net_q) && (rd_mask == mask_q);
    end
  end

  assign sts.cmd        = cmd_q;
  assign sts.bad_prefix = bad_q;
  assign sts.match      = rd_vld && hit;
  assign sts.done       = !rd_vld && !(idx < cur_count);
  assign sts.full       = (cur_count == CNT_W'(RULE_DEPTH));

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q  <= command;
      addr_q <= address;
      mask_q <= mask_in;
      net_q  <= address & mask_in;
      bad_q  <= (prefix_len > PLEN_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= '0;
      rd_vld <= 1'b0;
      sel    <= 1'b0;
    end else if (ctl.scan_start) begin
      idx    <= '0;
      rd_vld <= 1'b0;
      sel    <= ctl.scan_sel;
    end else if (ctl.scan_en) begin
      rd_vld <= issue;
      if (issue) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= sel ? deny_mem[idx[IDX_W-1:0]] : allow_mem[idx[IDX_W-1:0]];
    end
    if (ctl.write && !sel) begin
      allow_mem[allow_count[IDX_W-1:0]] <= {net_q, mask_q};
    end
    if (ctl.write && sel) begin
      deny_mem[deny_count[IDX_W-1:0]] <= {net_q, mask_q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      allow_count   <= '0;
      deny_count    <= '0;
      default_allow <= 1'b1;
    end else begin
      if (ctl.write && !sel) begin
        allow_count <= allow_count + 1'b1;
      end
      if (ctl.write && sel) begin
        deny_count <= deny_count + 1'b1;
      end
      if (cfg_wr_en) begin
        default_allow <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      res_allowed <= ctl.res_default ? default_allow : ctl.res_allowed;
      res_status  <= ctl.res_status;
    end
    if (ctl.emit) begin
      allowed    <= res_allowed;
      add_status <= res_status;
    end
  end

endmodule

[rtl/core/ip_cidr_allow_deny_filter_unit.sv]
// IPv4 CIDR allow/deny filter: one result per command, one command at a time.
// An add scans its target list, a check scans the allow list and then the deny list;
// an invalid prefix on an add or an unused command goes straight to the result. A scan
// reads one list entry per cycle and stops early on a hit. A new command is taken while
// the previous result waits; its own result is held until that one is taken by out_ready.
// Sync reset empties lists, default_allow=1.
module ip_cidr_allow_deny_filter_unit #(
  parameter int RULE_DEPTH = icadf_pkg::RULE_DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [icadf_pkg::CMD_W-1:0]    command,
  input  logic [icadf_pkg::ADDR_W-1:0]   address,
  input  logic [icadf_pkg::PLEN_W-1:0]   prefix_len,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           allowed,
  output logic [icadf_pkg::STATUS_W-1:0] add_status,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_wr_data
);
  import icadf_pkg::*;

  ctl_t ctl;
  sts_t sts;

  icadf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  icadf_dp #(
    .RULE_DEPTH (RULE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .sts         (sts),
    .command     (command),
    .address     (address),
    .prefix_len  (prefix_len),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .allowed     (allowed),
    .add_status  (add_status)
  );

endmodule

[rtl/core/icadf_chk.sv]
// Port-level checks for the CIDR filter, bound to the top level.
// Depends on icadf_pkg.
module icadf_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           allowed,
  input logic [icadf_pkg::STATUS_W-1:0] add_status
);
  import icadf_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(allowed) && $stable(add_status))
    else $error("output changed while stalled");

  a_verdict_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(allowed && (add_status != ST_ADDED)))
    else $error("allow verdict with nonzero add status");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second command taken while one is in flight");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind ip_cidr_allow_deny_filter_unit icadf_chk u_icadf_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .allowed    (allowed),
  .add_status (add_status)
);
